FILE: hw/rtl/cdec_pkg.sv
// Shared types, codes and helpers for the chunked transfer decoder.
package cdec_pkg;

	localparam int LEN_BITS_DEF = 32;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;

	// Offsets that turn an ASCII hex digit into its value.
	localparam logic [7:0] DIG_OFS_NUM   = 8'd48;
	localparam logic [7:0] DIG_OFS_UPPER = 8'd55;
	localparam logic [7:0] DIG_OFS_LOWER = 8'd87;

	typedef enum logic [2:0] {
		PH_SIZE_EMPTY  = 3'd0,
		PH_SIZE_DIGITS = 3'd1,
		PH_SIZE_CR     = 3'd2,
		PH_DATA        = 3'd3,
		PH_DATA_CR     = 3'd4,
		PH_DONE        = 3'd5,
		PH_ERROR       = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_FRAME    = 2'd0,
		ST_PAYLOAD  = 2'd1,
		ST_COMPLETE = 2'd2,
		ST_ERROR    = 2'd3
	} status_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] payload;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t h;
		logic [7:0] v;
		begin
			h.valid = 1'b1;
			v       = 8'd0;
			if (b >= 8'd48 && b <= 8'd57) begin
				v = b - DIG_OFS_NUM;
			end else if (b >= 8'd65 && b <= 8'd70) begin
				v = b - DIG_OFS_UPPER;
			end else if (b >= 8'd97 && b <= 8'd102) begin
				v = b - DIG_OFS_LOWER;
			end else begin
				h.valid = 1'b0;
			end
			h.value = v[3:0];
			return h;
		end
	endfunction

endpackage

FILE: hw/rtl/cdec_in_if.sv
// Input channel: one body byte per word with a restart flag.
interface cdec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       first_byte;

	modport source(output valid, output in_byte, output first_byte, input ready);
	modport sink(input valid, input in_byte, input first_byte, output ready);
endinterface

FILE: hw/rtl/cdec_out_if.sv
// Output channel: one status and payload byte per word.
interface cdec_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status_kind;
	logic [7:0] payload_byte;

	modport source(output valid, output status_kind, output payload_byte, input ready);
	modport sink(input valid, input status_kind, input payload_byte, output ready);
endinterface

FILE: hw/rtl/cdec_step.sv
// Next-state and result logic for one byte of the chunked body.
module cdec_step #(
	parameter int LEN_BITS = cdec_pkg::LEN_BITS_DEF
) (
	input  logic [7:0]          in_byte,
	input  logic                first_byte,
	input  cdec_pkg::phase_t    phase,
	input  logic [LEN_BITS-1:0] len,
	input  logic                last,
	output cdec_pkg::phase_t    phase_nxt,
	output logic [LEN_BITS-1:0] len_nxt,
	output logic                last_nxt,
	output cdec_pkg::result_t   res
);

	cdec_pkg::phase_t    ph;
	logic [LEN_BITS-1:0] cur_len;
	logic                cur_last;
	cdec_pkg::hex_digit_t dig;

	always_comb begin
		// A restart flag puts the decoder back at a fresh size line first.
		ph       = first_byte ? cdec_pkg::PH_SIZE_EMPTY : phase;
		cur_len  = first_byte ? '0 : len;
		cur_last = first_byte ? 1'b0 : last;
		dig      = cdec_pkg::hex_decode(in_byte);

		phase_nxt   = ph;
		len_nxt     = cur_len;
		last_nxt    = cur_last;
		res.status  = cdec_pkg::ST_FRAME;
		res.payload = 8'd0;

		unique case (ph)
			cdec_pkg::PH_SIZE_EMPTY, cdec_pkg::PH_SIZE_DIGITS: begin
				if (in_byte == cdec_pkg::CH_CR) begin
					phase_nxt = cdec_pkg::PH_SIZE_CR;
				end else if (!dig.valid || cur_len[LEN_BITS-1 -: 4] != 4'd0) begin
					// Not a digit, or one more digit would overflow the length.
					phase_nxt  = cdec_pkg::PH_ERROR;
					res.status = cdec_pkg::ST_ERROR;
				end else begin
					len_nxt   = {cur_len[LEN_BITS-5:0], dig.value};
					phase_nxt = cdec_pkg::PH_SIZE_DIGITS;
				end
			end
			cdec_pkg::PH_SIZE_CR: begin
				if (in_byte != cdec_pkg::CH_LF) begin
					phase_nxt  = cdec_pkg::PH_ERROR;
					res.status = cdec_pkg::ST_ERROR;
				end else begin
					last_nxt  = (cur_len == '0);
					phase_nxt = cdec_pkg::PH_DATA;
				end
			end
			cdec_pkg::PH_DATA: begin
				if (cur_len != '0) begin
					res.status  = cdec_pkg::ST_PAYLOAD;
					res.payload = in_byte;
					len_nxt     = cur_len - LEN_BITS'(1);
				end else if (in_byte == cdec_pkg::CH_CR) begin
					phase_nxt = cdec_pkg::PH_DATA_CR;
				end else begin
					phase_nxt  = cdec_pkg::PH_ERROR;
					res.status = cdec_pkg::ST_ERROR;
				end
			end
			cdec_pkg::PH_DATA_CR: begin
				if (in_byte != cdec_pkg::CH_LF) begin
					phase_nxt  = cdec_pkg::PH_ERROR;
					res.status = cdec_pkg::ST_ERROR;
				end else if (cur_last) begin
					phase_nxt  = cdec_pkg::PH_DONE;
					res.status = cdec_pkg::ST_COMPLETE;
				end else begin
					phase_nxt = cdec_pkg::PH_SIZE_EMPTY;
					len_nxt   = '0;
				end
			end
			default: begin
				// Done, error and the unused code all report an error.
				phase_nxt  = cdec_pkg::PH_ERROR;
				res.status = cdec_pkg::ST_ERROR;
			end
		endcase
	end

endmodule

FILE: hw/rtl/chunked_transfer_decoder_unit.sv
// Top level of the chunked transfer decoder: input register, step logic, result register.
//
//  channel  dir  word fields                 handshake
//  in_ch    in   in_byte[7:0], first_byte    valid/ready
//  out_ch   out  status_kind[1:0],           valid/ready
//                payload_byte[7:0]
//
// Each accepted word gives exactly one result word, via the input and result registers.
// One word per cycle while out_ch is ready; each byte is one pass through cdec_step.
// The input register and the result register decouple the two sides, so a new
// word is taken while a result waits. A stalled output stops the input after one word.
// arst_n clears valid flags and the decoder state (fresh size line, zero length).
module chunked_transfer_decoder_unit #(
	parameter int LEN_BITS = cdec_pkg::LEN_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	cdec_in_if.sink    in_ch,
	cdec_out_if.source out_ch
);

	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       first_byte_s1;

	cdec_pkg::phase_t    phase_q;
	logic [LEN_BITS-1:0] len_q;
	logic                last_q;

	cdec_pkg::phase_t    phase_nxt;
	logic [LEN_BITS-1:0] len_nxt;
	logic                last_nxt;
	cdec_pkg::result_t   res;

	logic              out_valid_q;
	cdec_pkg::result_t res_q;

	logic advance;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			in_byte_s1    <= in_ch.in_byte;
			first_byte_s1 <= in_ch.first_byte;
		end
	end

	cdec_step #(
		.LEN_BITS(LEN_BITS)
	) u_step (
		.in_byte   (in_byte_s1),
		.first_byte(first_byte_s1),
		.phase     (phase_q),
		.len       (len_q),
		.last      (last_q),
		.phase_nxt (phase_nxt),
		.len_nxt   (len_nxt),
		.last_nxt  (last_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cdec_pkg::PH_SIZE_EMPTY;
			len_q   <= '0;
			last_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			len_q   <= len_nxt;
			last_q  <= last_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status_kind  = res_q.status;
	assign out_ch.payload_byte = res_q.payload;

	a_complete_enters_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.status == cdec_pkg::ST_COMPLETE) |=> (phase_q == cdec_pkg::PH_DONE))
		else $error("completion did not leave the decoder in the done phase");

	a_error_enters_error: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.status == cdec_pkg::ST_ERROR) |=> (phase_q == cdec_pkg::PH_ERROR))
		else $error("format error did not leave the decoder in the error phase");

	a_payload_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.status == cdec_pkg::ST_PAYLOAD)
		|=> (len_q == $past(len_q) - LEN_BITS'(1)))
		else $error("payload byte did not decrement the remaining length");

	a_payload_zero_otherwise: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != cdec_pkg::ST_PAYLOAD) |-> (res_q.payload == 8'd0))
		else $error("payload byte is nonzero on a non-payload word");

endmodule
